// ===== hw/rtl/limit_order_book_matcher_assert.svh =====
// Assertion macros for the limit order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
// check that a condition implies another on the same edge
`define LOBM_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("lobm check failed");
// check that a condition implies another on the next edge
`define LOBM_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("lobm check failed");
`endif

// ===== hw/rtl/lobm_pkg.sv =====
// Types and codes shared by the order book matcher modules
package lobm_pkg;
   localparam logic [1:0] EV_TRADE  = 2'd0;
   localparam logic [1:0] EV_RESTED = 2'd1;
   localparam logic [1:0] EV_FILLED = 2'd2;
   localparam logic [1:0] EV_FULL   = 2'd3;

   typedef struct packed {
      logic [7:0]  price;
      logic [15:0] amount;
      logic [15:0] trader;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic      found;
      entry_type ent;
   } token_type;

   typedef struct packed {
      logic        remove;
      logic        dec;
      logic        append;
      logic [15:0] dec_amt;
      entry_type   new_ent;
   } book_op_type;
endpackage

// ===== hw/rtl/lobm_cell.sv =====
// One resting order slot with its stage of the best-price search chain
module lobm_cell #(
   parameter int DEPTH = 32,
   parameter int IDX   = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(DEPTH+1)-1:0]     count_i,
   input  lobm_pkg::book_op_type          op_i,
   input  logic [$clog2(DEPTH)-1:0]       op_idx_i,
   input  lobm_pkg::entry_type            next_ent_i,
   input  logic                           sell_i,
   input  logic [7:0]                     limit_i,
   input  lobm_pkg::token_type            tok_i,
   input  logic [$clog2(DEPTH)-1:0]       tok_idx_i,
   output lobm_pkg::entry_type            ent_o,
   output lobm_pkg::token_type            tok_o,
   output logic [$clog2(DEPTH)-1:0]       tok_idx_o
);
   import lobm_pkg::*;
   localparam int CW = $clog2(DEPTH+1);
   localparam int IW = $clog2(DEPTH);
   localparam logic [CW-1:0] MY_POS = CW'(IDX);
   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   entry_type       ent_ff, ent_in;
   token_type       tok_ff, tok_in;
   logic [IW-1:0]   tidx_ff, tidx_in;
   logic            valid, ok, better;

   always_comb begin
      valid  = MY_POS < count_i;
      ok     = valid && (sell_i ? (ent_ff.price >= limit_i) : (ent_ff.price <= limit_i));
      better = !tok_i.found ||
               (sell_i ? (ent_ff.price > tok_i.ent.price) : (ent_ff.price < tok_i.ent.price));
      tok_in  = tok_i;
      tidx_in = tok_idx_i;
      if (ok && better) begin
         tok_in.found = 1'b1;
         tok_in.ent   = ent_ff;
         tidx_in      = MY_IDX;
      end
      ent_in = ent_ff;
      if (op_i.remove && (MY_POS >= {1'b0, op_idx_i}) && (MY_POS + 1'b1 < count_i)) begin
         ent_in = next_ent_i;
      end else if (op_i.dec && (MY_IDX == op_idx_i)) begin
         ent_in.amount = ent_ff.amount - op_i.dec_amt;
      end else if (op_i.append && (MY_POS == count_i)) begin
         ent_in = op_i.new_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.found <= 1'b0;
      end else begin
         tok_ff.found <= tok_in.found;
      end
      tok_ff.ent <= tok_in.ent;
      tidx_ff    <= tidx_in;
      ent_ff     <= ent_in;
   end

   assign ent_o     = ent_ff;
   assign tok_o     = tok_ff;
   assign tok_idx_o = tidx_ff;
endmodule

// ===== hw/rtl/lobm_book.sv =====
// One side of the book: a row of order cells and its fill count
module lobm_book #(
   parameter int DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lobm_pkg::book_op_type          op_i,
   input  logic [$clog2(DEPTH)-1:0]       op_idx_i,
   input  logic                           sell_i,
   input  logic [7:0]                     limit_i,
   output lobm_pkg::token_type            best_o,
   output logic [$clog2(DEPTH)-1:0]       best_idx_o,
   output logic [$clog2(DEPTH+1)-1:0]     count_o
);
   import lobm_pkg::*;
   localparam int CW = $clog2(DEPTH+1);
   localparam int IW = $clog2(DEPTH);

   logic [CW-1:0]   count_ff, count_in;
   entry_type       ents  [DEPTH];
   token_type       toks  [DEPTH+1];
   logic [IW-1:0]   tidx  [DEPTH+1];
   entry_type       nexts [DEPTH];

   assign toks[0] = '0;
   assign tidx[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i + 1 < DEPTH) begin : g_mid
         assign nexts[i] = ents[i+1];
      end else begin : g_end
         assign nexts[i] = '0;
      end
      lobm_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count_i    (count_ff),
         .op_i       (op_i),
         .op_idx_i   (op_idx_i),
         .next_ent_i (nexts[i]),
         .sell_i     (sell_i),
         .limit_i    (limit_i),
         .tok_i      (toks[i]),
         .tok_idx_i  (tidx[i]),
         .ent_o      (ents[i]),
         .tok_o      (toks[i+1]),
         .tok_idx_o  (tidx[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op_i.remove && count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end else if (op_i.append && count_ff < CW'(DEPTH)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign best_o     = toks[DEPTH];
   assign best_idx_o = tidx[DEPTH];
   assign count_o    = count_ff;
endmodule

// ===== hw/rtl/limit_order_book_matcher.sv =====
// Price-time priority order book matcher: control sequencer and output register
// One order at a time. Each match search runs the best-price token down the row of
// BOOK_DEPTH cells; a trade then passes through S_MUL, which forms the record, and
// S_OUT, which waits for the output to be taken, and the final record through S_FINAL
// and S_OUTF. An order that leaves a remainder to rest or reject runs one more search
// that finds no match. Books reset to empty at once; trade records leave in match
// order, the final record last with rsp_tlast high.
module limit_order_book_matcher #(
   parameter int PRICE_LEVELS = 256,
   parameter int BOOK_DEPTH   = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [71:0]   req_tdata,   // limit_price, order_amount, trader_id, order_time
   input  logic          req_tuser,   // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata,   // buyer_id, seller_id, trade_amount, trade_price,
                                      // trade_value, remaining_amount
   output logic [1:0]    rsp_tuser,   // event_kind
   output logic          rsp_tlast    // last_result
);
   import lobm_pkg::*;
   localparam int CW = $clog2(BOOK_DEPTH+1);
   localparam int IW = $clog2(BOOK_DEPTH);
   localparam int SW = $clog2(BOOK_DEPTH+1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_OUT    = 3'd3;
   localparam logic [2:0] S_FINAL  = 3'd4;
   localparam logic [2:0] S_OUTF   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [SW-1:0] scnt_ff, scnt_in;
   logic          sell_ff, sell_in;
   logic [7:0]    limit_ff, limit_in;
   logic [15:0]   remain_ff, remain_in;
   logic [15:0]   trader_ff, trader_in;
   logic [31:0]   stamp_ff, stamp_in;
   logic [15:0]   amt_ff, amt_in;
   logic [7:0]    price_ff, price_in;
   logic [15:0]   other_ff, other_in;
   logic          full_ff, full_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic          rvalid_ff, rvalid_in;
   logic [97:0]   rdata_ff, rdata_in;
   logic          rlast_ff, rlast_in;

   book_op_type   bid_op, ask_op;
   token_type     bid_best, ask_best, best;
   logic [IW-1:0] bid_bidx, ask_bidx;
   logic [CW-1:0] bid_count, ask_count;
   logic [7:0]    lim_raw;
   logic [15:0]   buyer, seller, amt_min;
   logic [31:0]   btime, stime;
   logic [7:0]    bprice, sprice;
   logic [23:0]   value;
   logic [CW-1:0] own_count;
   logic [1:0]    fkind;

   lobm_book #(.DEPTH(BOOK_DEPTH)) u_bid (
      .clock (clock), .reset (reset), .op_i (bid_op), .op_idx_i (bidx_ff),
      .sell_i (sell_ff), .limit_i (limit_ff), .best_o (bid_best),
      .best_idx_o (bid_bidx), .count_o (bid_count)
   );
   lobm_book #(.DEPTH(BOOK_DEPTH)) u_ask (
      .clock (clock), .reset (reset), .op_i (ask_op), .op_idx_i (bidx_ff),
      .sell_i (sell_ff), .limit_i (limit_ff), .best_o (ask_best),
      .best_idx_o (ask_bidx), .count_o (ask_count)
   );

   assign lim_raw    = req_tdata[7:0];
   assign best       = sell_ff ? bid_best : ask_best;
   assign own_count  = sell_ff ? ask_count : bid_count;
   assign amt_min    = (best.ent.amount < remain_ff) ? best.ent.amount : remain_ff;
   assign value      = {8'd0, amt_ff} * {16'd0, price_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff[97:2];
   assign rsp_tuser  = rdata_ff[1:0];
   assign rsp_tlast  = rlast_ff;

   always_comb begin
      state_in  = state_ff;
      scnt_in   = scnt_ff;
      sell_in   = sell_ff;
      limit_in  = limit_ff;
      remain_in = remain_ff;
      trader_in = trader_ff;
      stamp_in  = stamp_ff;
      amt_in    = amt_ff;
      price_in  = price_ff;
      other_in  = other_ff;
      full_in   = full_ff;
      bidx_in   = bidx_ff;
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;
      rlast_in  = rlast_ff;
      bid_op    = '0;
      ask_op    = '0;
      buyer     = '0;
      seller    = '0;
      btime     = '0;
      stime     = '0;
      bprice    = '0;
      sprice    = '0;
      fkind     = EV_FILLED;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sell_in   = req_tuser;
               limit_in  = (32'(lim_raw) > 32'(PRICE_LEVELS - 1)) ?
                           8'(PRICE_LEVELS - 1) : lim_raw;
               remain_in = req_tdata[23:8];
               trader_in = req_tdata[39:24];
               stamp_in  = req_tdata[71:40];
               scnt_in   = '0;
               state_in  = (req_tdata[23:8] == '0) ? S_FINAL : S_SEARCH;
            end
         end
         S_SEARCH: begin
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == SW'(BOOK_DEPTH)) begin
               if (!best.found) begin
                  state_in = S_FINAL;
               end else begin
                  if (sell_ff) begin
                     btime  = best.ent.stamp;
                     stime  = stamp_ff;
                     bprice = best.ent.price;
                     sprice = limit_ff;
                  end else begin
                     btime  = stamp_ff;
                     stime  = best.ent.stamp;
                     bprice = limit_ff;
                     sprice = best.ent.price;
                  end
                  amt_in    = amt_min;
                  price_in  = (stime < btime) ? sprice : bprice;
                  other_in  = best.ent.trader;
                  full_in   = (best.ent.amount == amt_min);
                  bidx_in   = sell_ff ? bid_bidx : ask_bidx;
                  remain_in = remain_ff - amt_min;
                  state_in  = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (sell_ff) begin
               bid_op.remove  = full_ff;
               bid_op.dec     = !full_ff;
               bid_op.dec_amt = amt_ff;
               buyer          = other_ff;
               seller         = trader_ff;
            end else begin
               ask_op.remove  = full_ff;
               ask_op.dec     = !full_ff;
               ask_op.dec_amt = amt_ff;
               buyer          = trader_ff;
               seller         = other_ff;
            end
            rvalid_in = 1'b1;
            rlast_in  = 1'b0;
            rdata_in  = {remain_ff, value, price_ff, amt_ff, seller, buyer, EV_TRADE};
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               scnt_in   = '0;
               state_in  = (remain_ff == '0) ? S_FINAL : S_SEARCH;
            end
         end
         S_FINAL: begin
            if (remain_ff == '0) begin
               fkind = EV_FILLED;
            end else if (own_count < CW'(BOOK_DEPTH)) begin
               fkind = EV_RESTED;
               if (sell_ff) begin
                  ask_op.append  = 1'b1;
                  ask_op.new_ent = '{limit_ff, remain_ff, trader_ff, stamp_ff};
               end else begin
                  bid_op.append  = 1'b1;
                  bid_op.new_ent = '{limit_ff, remain_ff, trader_ff, stamp_ff};
               end
            end else begin
               fkind = EV_FULL;
            end
            buyer     = sell_ff ? 16'd0 : trader_ff;
            seller    = sell_ff ? trader_ff : 16'd0;
            rvalid_in = 1'b1;
            rlast_in  = 1'b1;
            rdata_in  = {remain_ff, 24'd0, limit_ff, 16'd0, seller, buyer, fkind};
            state_in  = S_OUTF;
         end
         S_OUTF: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         scnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         scnt_ff   <= scnt_in;
      end
      sell_ff   <= sell_in;
      limit_ff  <= limit_in;
      remain_ff <= remain_in;
      trader_ff <= trader_in;
      stamp_ff  <= stamp_in;
      amt_ff    <= amt_in;
      price_ff  <= price_in;
      other_ff  <= other_in;
      full_ff   <= full_in;
      bidx_ff   <= bidx_in;
      rdata_ff  <= rdata_in;
      rlast_ff  <= rlast_in;
   end

`include "limit_order_book_matcher_assert.svh"
   `LOBM_ASSERT_NOW(a_no_accept_busy, req_tready, !rvalid_ff)
   `LOBM_ASSERT_NOW(a_bid_count, 1'b1, bid_count <= CW'(BOOK_DEPTH))
   `LOBM_ASSERT_NOW(a_trade_nonzero, rvalid_ff && !rlast_ff, rdata_ff[49:34] != 16'd0)
   `LOBM_ASSERT_NEXT(a_final_idle, rvalid_ff && rlast_ff && rsp_tready, state_ff == S_IDLE)
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the limit order book matcher: directed and random orders
`timescale 1ns / 100ps
module tb;
   import lobm_pkg::*;

   localparam int DEPTH = 32;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] buyer;
      logic [15:0] seller;
      logic [15:0] amount;
      logic [7:0]  price;
      logic [23:0] value;
      logic [15:0] remain;
      logic        last;
   } fill_type;

   typedef struct {
      logic [7:0]  price;
      logic [15:0] amount;
      logic [15:0] trader;
      logic [31:0] stamp;
   } rest_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [71:0]   req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [95:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;

   rest_type bids[$];
   rest_type asks[$];
   fill_type fills_due[$];
   int errors = 0;
   int orders_sent = 0;
   int fills_seen = 0;
   int trades_seen = 0;
   bit sink_calm = 0;
   bit src_calm = 0;
   int hold_off = 0;
   int stall_asked = 0;
   int stall_done = 0;
   logic [31:0] stamp_now = 32'd100;

   limit_order_book_matcher DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("limit_order_book_matcher verification failed");
      $finish;
   end

   function automatic fill_type make_fill(logic [1:0] kind, logic [15:0] buyer,
         logic [15:0] seller, logic [15:0] amount, logic [7:0] price,
         logic [15:0] remain, logic last);
      fill_type f;
      f.kind = kind;
      f.buyer = buyer;
      f.seller = seller;
      f.amount = amount;
      f.price = price;
      f.value = 24'(amount) * 24'(price);
      f.remain = remain;
      f.last = last;
      return f;
   endfunction

   task automatic match_order(logic is_sell, logic [7:0] limit, logic [15:0] amount,
         logic [15:0] trader, logic [31:0] stamp);
      logic [15:0] left;
      int best;
      logic [15:0] amt;
      logic [7:0] px;
      rest_type o;
      rest_type r;
      left = amount;
      while (left > 0) begin
         best = -1;
         if (is_sell) begin
            foreach (bids[i])
               if (bids[i].price >= limit && (best < 0 || bids[i].price > bids[best].price))
                  best = i;
         end else begin
            foreach (asks[i])
               if (asks[i].price <= limit && (best < 0 || asks[i].price < asks[best].price))
                  best = i;
         end
         if (best < 0) break;
         o = is_sell ? bids[best] : asks[best];
         amt = o.amount < left ? o.amount : left;
         if (is_sell) px = (stamp < o.stamp) ? limit : o.price;
         else px = (o.stamp < stamp) ? o.price : limit;
         left -= amt;
         o.amount -= amt;
         if (is_sell) begin
            if (o.amount == 0) bids.delete(best); else bids[best] = o;
            fills_due.push_back(make_fill(EV_TRADE, o.trader, trader, amt, px, left, 1'b0));
         end else begin
            if (o.amount == 0) asks.delete(best); else asks[best] = o;
            fills_due.push_back(make_fill(EV_TRADE, trader, o.trader, amt, px, left, 1'b0));
         end
      end
      r.price = limit;
      r.amount = left;
      r.trader = trader;
      r.stamp = stamp;
      fills_due.push_back(make_fill(
         left == 0 ? EV_FILLED :
         ((is_sell ? asks.size() : bids.size()) < DEPTH ? EV_RESTED : EV_FULL),
         is_sell ? 16'd0 : trader, is_sell ? trader : 16'd0, 16'd0, limit, left, 1'b1));
      if (left != 0) begin
         if (is_sell && asks.size() < DEPTH) asks.push_back(r);
         else if (!is_sell && bids.size() < DEPTH) bids.push_back(r);
      end
   endtask

   task automatic send_order(logic is_sell, logic [7:0] limit, logic [15:0] amount,
         logic [15:0] trader, logic [31:0] stamp);
      int gap;
      if (!src_calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= is_sell;
      req_tdata <= {stamp, trader, amount, limit};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      match_order(is_sell, limit, amount, trader, stamp);
      orders_sent++;
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_next(logic is_sell, logic [7:0] limit, logic [15:0] amount,
         logic [15:0] trader);
      stamp_now += $urandom_range(0, 3);
      send_order(is_sell, limit, amount, trader, stamp_now);
   endtask

   task automatic drain;
      while (fills_due.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   always @(posedge clock) begin
      fill_type got;
      fill_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.buyer = rsp_tdata[15:0];
         got.seller = rsp_tdata[31:16];
         got.amount = rsp_tdata[47:32];
         got.price = rsp_tdata[55:48];
         got.value = rsp_tdata[79:56];
         got.remain = rsp_tdata[95:80];
         got.last = rsp_tlast;
         fills_seen++;
         if (got.kind == EV_TRADE) trades_seen++;
         if (fills_due.size() == 0) begin
            $display("%t unexpected record %h", $time, got);
            errors++;
         end else begin
            want = fills_due.pop_front();
            if (got !== want) begin
               $display("%t expected kind=%0d buy=%0d sell=%0d amt=%0d px=%0d",
                  $time, want.kind, want.buyer, want.seller, want.amount, want.price);
               $display("%t          val=%0d rem=%0d last=%0d",
                  $time, want.value, want.remain, want.last);
               $display("%t actual   kind=%0d buy=%0d sell=%0d amt=%0d px=%0d",
                  $time, got.kind, got.buyer, got.seller, got.amount, got.price);
               $display("%t          val=%0d rem=%0d last=%0d",
                  $time, got.value, got.remain, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_asked != stall_done) begin
         stall_done <= stall_asked;
         hold_off <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
         hold_off <= $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_field_extremes;
      send_next(1'b0, 8'd0, 16'd0, 16'hFFFF);
      send_next(1'b1, 8'd255, 16'd0, 16'h0000);
      send_next(1'b0, 8'd255, 16'hFFFF, 16'hFFFF);
      send_next(1'b1, 8'd0, 16'hFFFF, 16'hAAAA);
      send_order(1'b0, 8'd10, 16'h5555, 16'h5555, 32'hFFFFFFFF);
      send_order(1'b1, 8'd5, 16'h1234, 16'h1111, 32'hFFFFFFFF);
      send_order(1'b1, 8'd8, 16'h5555, 16'h2222, 32'h0);
      drain();
   endtask

   task automatic test_price_time_priority;
      send_order(1'b1, 8'd50, 16'd10, 16'd1, 32'd200);
      send_order(1'b1, 8'd40, 16'd10, 16'd2, 32'd300);
      send_order(1'b1, 8'd40, 16'd10, 16'd3, 32'd250);
      send_order(1'b0, 8'd60, 16'd25, 16'd4, 32'd100);
      send_order(1'b0, 8'd60, 16'd3, 16'd5, 32'd900);
      send_order(1'b1, 8'd20, 16'd2, 16'd6, 32'd900);
      send_order(1'b1, 8'd0, 16'd100, 16'd7, 32'd1000);
      drain();
   endtask

   task automatic test_book_full;
      bit last_side;
      for (int i = 0; i < DEPTH + 2; i++)
         send_next(1'b0, 8'($urandom_range(0, 20)), 16'($urandom_range(1, 9)), 16'(i));
      src_calm = 1;
      stall_asked++;
      for (int i = 0; i < 6; i++)
         send_next(1'b1, 8'($urandom_range(0, 5)), 16'($urandom_range(1, 30)), 16'(100 + i));
      src_calm = 0;
      drain();
      last_side = 1;
      for (int i = 0; i < DEPTH + 2; i++)
         send_next(last_side, 8'd200, 16'd3, 16'(200 + i));
      send_next(1'b0, 8'd255, 16'd200, 16'd999);
      drain();
   endtask

   task automatic test_random_orders;
      logic is_sell;
      for (int n = 0; n < 130; n++) begin
         if (n == 100) begin
            sink_calm = 1;
            src_calm = 1;
         end
         is_sell = 1'($urandom_range(0, 1));
         stamp_now = $urandom_range(0, 9) == 0 ? $urandom : stamp_now + $urandom_range(0, 2);
         send_order(is_sell,
            $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(120, 136)),
            $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 60)),
            16'($urandom), stamp_now);
         if (bids.size() > 24 && asks.size() > 24) begin
            send_next(1'b0, 8'd255, 16'hFFFF, 16'($urandom));
            send_next(1'b1, 8'd0, 16'hFFFF, 16'($urandom));
         end
      end
   endtask

   initial begin
      int waited;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_field_extremes();
      test_price_time_priority();
      test_book_full();
      test_random_orders();
      waited = 0;
      while (fills_due.size() > 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (fills_due.size() > 0) begin
         $display("%t %0d records never arrived", $time, fills_due.size());
         errors++;
      end
      $display("%0d orders sent, %0d records checked, %0d of them trades",
         orders_sent, fills_seen, trades_seen);
      $display("covered price-time priority, partial fills, saturated prices, full books");
      if (errors == 0)
         $display("limit_order_book_matcher verification clean");
      else
         $display("limit_order_book_matcher verification failed");
      $finish;
   end
endmodule
